@@ hdl/bdgc_pkg.sv @@
// ----------------------------------------------------------------------------
// bdgc_pkg: shared types and constants for the button gesture classifier
// Gesture codes, configuration register indexes and register reset values.
// ----------------------------------------------------------------------------
package bdgc_pkg;

    // Widths of the fixed fields
    localparam int GESTURE_W = 2;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Gesture reported with each item
    typedef enum logic [GESTURE_W-1:0] {
        GESTURE_NONE   = 2'd0,
        GESTURE_SINGLE = 2'd1,
        GESTURE_DOUBLE = 2'd2,
        GESTURE_LONG   = 2'd3
    } t_gesture;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_WINDOW = 2'd0,
        CFG_LONG_LIMIT      = 2'd1,
        CFG_SHORT_LIMIT     = 2'd2,
        CFG_DOUBLE_GAP      = 2'd3
    } t_cfg_index;

    // Register values after reset, in milliseconds
    localparam logic [CFG_W-1:0] RST_DEBOUNCE_WINDOW = 16'd30;
    localparam logic [CFG_W-1:0] RST_LONG_LIMIT      = 16'd800;
    localparam logic [CFG_W-1:0] RST_SHORT_LIMIT     = 16'd400;
    localparam logic [CFG_W-1:0] RST_DOUBLE_GAP      = 16'd300;

endpackage

@@ hdl/button_debounce_gesture_classifier.sv @@
// ----------------------------------------------------------------------------
// button_debounce_gesture_classifier: debounced single/double/long detector
// Each item is one poll (raw level and millisecond time); each gives one code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel : i_in_valid / o_in_stall carry one poll per item, with
//                   i_raw_pressed and the 32-bit time i_now_ms.
//   Output channel: o_out_valid / i_out_stall carry one gesture per poll
//                   (0 none, 1 single, 2 double, 3 long hold).
//   Config port   : i_cfg_we writes i_cfg_data to the register at
//                   i_cfg_index; write only while no item is in flight.
//   Result path   : each gesture is registered in the result register or skid.
//   Throughput    : one poll per cycle while o_in_stall is low; the
//                   debounce, press timing and gap checks are one pass
//                   of adds and compares on the state registers at acceptance.
//   Stall         : a two-entry output stage (result register plus skid)
//                   holds results; o_in_stall rises only when both are full.
//   Reset         : registers return to their defaults, the button is taken
//                   as released, and no result is pending.
module button_debounce_gesture_classifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_raw_pressed,
    input  logic [bdgc_pkg::TIME_W-1:0]         i_now_ms,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [bdgc_pkg::GESTURE_W-1:0]      o_gesture,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [bdgc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bdgc_pkg::CFG_W-1:0]          i_cfg_data
);
    import bdgc_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0]  r_debounce_window;
    logic [CFG_W-1:0]  r_long_limit;
    logic [CFG_W-1:0]  r_short_limit;
    logic [CFG_W-1:0]  r_double_gap;

    // Classifier state
    logic              r_stable_level;
    logic              r_previous_raw;
    logic [TIME_W-1:0] r_debounce_deadline;
    logic              r_press_tracked;
    logic [TIME_W-1:0] r_press_start;
    logic              r_single_pending;
    logic [TIME_W-1:0] r_single_deadline;
    t_gesture          r_latched_code;

    // Next state
    logic              n_stable_level;
    logic              n_previous_raw;
    logic [TIME_W-1:0] n_debounce_deadline;
    logic              n_press_tracked;
    logic [TIME_W-1:0] n_press_start;
    logic              n_single_pending;
    logic [TIME_W-1:0] n_single_deadline;
    t_gesture          n_latched_code;
    t_gesture          n_code;

    // Output stage
    logic              r_out_valid;
    t_gesture          r_out_code;
    logic              r_skid_valid;
    t_gesture          r_skid_code;

    logic              w_accept;
    logic              w_take;
    logic [TIME_W-1:0] w_armed_deadline;
    logic              w_window_open;
    logic              w_stable_edge;
    logic [TIME_W-1:0] w_held;

    assign o_in_stall  = r_skid_valid;
    assign w_accept    = i_in_valid && !r_skid_valid;
    assign w_take      = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_gesture   = r_out_code;

    // Work out one poll: debounce, classify the stable edge, pick the code
    always_comb begin
        n_previous_raw    = i_raw_pressed;
        n_press_tracked   = r_press_tracked;
        n_press_start     = r_press_start;
        n_single_pending  = r_single_pending;
        n_single_deadline = r_single_deadline;
        n_latched_code    = r_latched_code;
        n_code            = GESTURE_NONE;
        w_held            = i_now_ms - r_press_start;

        // arm the debounce window on a raw change
        if (i_raw_pressed != r_previous_raw) begin
            w_armed_deadline = i_now_ms + {{(TIME_W-CFG_W){1'b0}}, r_debounce_window};
        end else begin
            w_armed_deadline = r_debounce_deadline;
        end
        w_window_open       = (w_armed_deadline != '0) && (i_now_ms < w_armed_deadline);
        n_debounce_deadline = w_window_open ? w_armed_deadline : '0;
        w_stable_edge       = !w_window_open && (i_raw_pressed != r_stable_level);
        n_stable_level      = w_stable_edge ? i_raw_pressed : r_stable_level;

        // classify the press on a stable edge
        if (w_stable_edge) begin
            if (i_raw_pressed) begin
                if (!r_press_tracked) begin
                    n_press_tracked = 1'b1;
                    n_press_start   = i_now_ms;
                end
            end else if (r_press_tracked) begin
                n_press_tracked = 1'b0;
                if (w_held >= {{(TIME_W-CFG_W){1'b0}}, r_long_limit}) begin
                    n_single_pending = 1'b0;
                    n_latched_code   = GESTURE_LONG;
                end else if (w_held <= {{(TIME_W-CFG_W){1'b0}}, r_short_limit}) begin
                    if (r_single_pending) begin
                        n_single_pending = 1'b0;
                        n_latched_code   = GESTURE_DOUBLE;
                    end else begin
                        n_single_pending  = 1'b1;
                        n_single_deadline = i_now_ms
                                          + {{(TIME_W-CFG_W){1'b0}}, r_double_gap};
                    end
                end
            end
        end

        // latched code first, then a due single
        if (n_latched_code != GESTURE_NONE) begin
            n_code         = n_latched_code;
            n_latched_code = GESTURE_NONE;
        end else if (n_single_pending && !n_stable_level
                     && (i_now_ms >= n_single_deadline)) begin
            n_single_pending = 1'b0;
            n_code           = GESTURE_SINGLE;
        end
    end

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_window <= RST_DEBOUNCE_WINDOW;
            r_long_limit      <= RST_LONG_LIMIT;
            r_short_limit     <= RST_SHORT_LIMIT;
            r_double_gap      <= RST_DOUBLE_GAP;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DEBOUNCE_WINDOW: r_debounce_window <= i_cfg_data;
                CFG_LONG_LIMIT:      r_long_limit      <= i_cfg_data;
                CFG_SHORT_LIMIT:     r_short_limit     <= i_cfg_data;
                CFG_DOUBLE_GAP:      r_double_gap      <= i_cfg_data;
                default:             r_double_gap      <= r_double_gap;
            endcase
        end
    end

    // Advance classifier state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_level      <= 1'b0;
            r_previous_raw      <= 1'b0;
            r_debounce_deadline <= '0;
            r_press_tracked     <= 1'b0;
            r_press_start       <= '0;
            r_single_pending    <= 1'b0;
            r_single_deadline   <= '0;
            r_latched_code      <= GESTURE_NONE;
        end else if (w_accept) begin
            r_stable_level      <= n_stable_level;
            r_previous_raw      <= n_previous_raw;
            r_debounce_deadline <= n_debounce_deadline;
            r_press_tracked     <= n_press_tracked;
            r_press_start       <= n_press_start;
            r_single_pending    <= n_single_pending;
            r_single_deadline   <= n_single_deadline;
            r_latched_code      <= n_latched_code;
        end
    end

    // Hold results in the output register and the skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_accept;
            end
        end else if (w_accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid  <= 1'b1;
            end
        end
    end

    // Move payload alongside the valid flags
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_code <= r_skid_valid ? r_skid_code : n_code;
        end else if (w_accept && !r_out_valid) begin
            r_out_code <= n_code;
        end
        if (!w_take && w_accept && r_out_valid) begin
            r_skid_code <= n_code;
        end
    end

endmodule

@@ tb/tb_button_debounce_gesture_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_gesture_classifier: self-checking bench for the classifier
// Drives polls made of clean and bouncing presses, near-limit press lengths,
// noise and clock wrap. A tracker class mirrors the debounce and gesture
// state and checks every gesture in order. Both handshakes idle and stall at
// random, and each settings phase opens with a long output hold-off.
// ----------------------------------------------------------------------------
module tb_button_debounce_gesture_classifier;

    import bdgc_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_POLLS  = 300;
    localparam int PHASES       = 6;
    localparam int HOLD_OFF_LEN = 150;
    localparam int DRAIN_CYCLES = 8;

    // ------------------------------------------------------------------------
    // Gesture tracker: mirrors the debounce and press state, queues the
    // gesture each accepted poll must produce and checks the returned ones.
    // ------------------------------------------------------------------------
    class gesture_tracker;
        logic [CFG_W-1:0]  debounce_ms, long_ms, short_ms, gap_ms;
        bit                stable_lvl, last_raw, tracked, single_wait;
        logic [TIME_W-1:0] settle_at, press_t0, single_due;
        t_gesture          latched;
        t_gesture          due_gestures[$];
        int                errors;

        function new();
            debounce_ms = RST_DEBOUNCE_WINDOW;
            long_ms     = RST_LONG_LIMIT;
            short_ms    = RST_SHORT_LIMIT;
            gap_ms      = RST_DOUBLE_GAP;
            stable_lvl  = 1'b0;
            last_raw    = 1'b0;
            tracked     = 1'b0;
            single_wait = 1'b0;
            settle_at   = '0;
            press_t0    = '0;
            single_due  = '0;
            latched     = GESTURE_NONE;
            errors      = 0;
        endfunction

        function void set_reg(t_cfg_index idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_DEBOUNCE_WINDOW: debounce_ms = val;
                CFG_LONG_LIMIT:      long_ms     = val;
                CFG_SHORT_LIMIT:     short_ms    = val;
                CFG_DOUBLE_GAP:      gap_ms      = val;
                default: ;
            endcase
        endfunction

        // Classify a change of the debounced level
        function void take_edge(logic [TIME_W-1:0] t);
            logic [TIME_W-1:0] held;
            if (stable_lvl) begin
                if (!tracked) begin
                    tracked  = 1'b1;
                    press_t0 = t;
                end
            end else if (tracked) begin
                tracked = 1'b0;
                held    = t - press_t0;
                if (held >= {16'd0, long_ms}) begin
                    single_wait = 1'b0;
                    latched     = GESTURE_LONG;
                end else if (held > {16'd0, short_ms}) begin
                    // middle length: drop it, keep any waiting single
                end else if (single_wait) begin
                    // second short press, no matter how late
                    single_wait = 1'b0;
                    latched     = GESTURE_DOUBLE;
                end else begin
                    single_wait = 1'b1;
                    single_due  = t + {16'd0, gap_ms};
                end
            end
        endfunction

        function void note_poll(bit raw, logic [TIME_W-1:0] t);
            t_gesture code;
            code = GESTURE_NONE;
            // a raw change opens the window; a sum of zero means no window
            if (raw != last_raw) begin
                settle_at = t + {16'd0, debounce_ms};
                last_raw  = raw;
            end
            // plain unsigned compare, not wrap-aware
            if (settle_at == '0 || t >= settle_at) begin
                settle_at = '0;
                if (raw != stable_lvl) begin
                    stable_lvl = raw;
                    take_edge(t);
                end
            end
            // latched double or long goes out ahead of a due single
            if (latched != GESTURE_NONE) begin
                code    = latched;
                latched = GESTURE_NONE;
            end else if (single_wait && !stable_lvl && t >= single_due) begin
                single_wait = 1'b0;
                code        = GESTURE_SINGLE;
            end
            due_gestures.push_back(code);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] gesture error: %s", $time, msg);
        endtask

        task check_gesture(logic [GESTURE_W-1:0] got);
            t_gesture want;
            if (due_gestures.size() == 0) begin
                report($sformatf("gesture %0d returned with none pending", got));
            end else begin
                want = due_gestures.pop_front();
                if (got !== want)
                    report($sformatf("got %0d, want %0d (%s)", got, want, want.name()));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_raw_pressed;
    logic [TIME_W-1:0]    i_now_ms;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [GESTURE_W-1:0] o_gesture;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    gesture_tracker    tracker;
    logic [TIME_W-1:0] clock_ms;
    int                polls_sent;
    int                cycle_count;
    bit                send_jitter;
    bit                stall_jitter;
    bit                hold_off_req;

    button_debounce_gesture_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_raw_pressed (i_raw_pressed),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_gesture     (o_gesture),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL button_debounce_gesture_classifier");
            $finish;
        end
    end

    // Check each gesture taken by the receiver
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_gesture(o_gesture);
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(12, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver stall: random runs, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        int run_left;
        stall_left  = 0;
        run_left    = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_LEN;
            end
            if (stall_left == 0 && run_left == 0) begin
                run_left   = $urandom_range(1, 16);
                stall_left = stall_jitter ? pick_gap() : 0;
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                run_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------
    // Offer one poll and hold it until taken
    task automatic send_poll(bit raw, logic [TIME_W-1:0] stamp);
        int gap;
        gap = send_jitter ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_raw_pressed <= raw;
        i_now_ms      <= stamp;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_poll(raw, stamp);
        polls_sent++;
    endtask

    // Drop valid and wait for every gesture to come back
    task automatic drain_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.due_gestures.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_setting(t_cfg_index idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        tracker.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] lng,
                                  logic [CFG_W-1:0] sht, logic [CFG_W-1:0] gap);
        drain_block();
        write_setting(CFG_DEBOUNCE_WINDOW, deb);
        write_setting(CFG_LONG_LIMIT, lng);
        write_setting(CFG_SHORT_LIMIT, sht);
        write_setting(CFG_DOUBLE_GAP, gap);
    endtask

    // Hold one level for span ms: the change poll, then fillers, one of them
    // exactly at the end of the debounce window when it ends within the span
    task automatic level_run(bit raw, int unsigned span);
        logic [TIME_W-1:0] start;
        int unsigned       at, nxt, win, max_step;
        start    = clock_ms;
        win      = 32'(tracker.debounce_ms);
        max_step = span / 5 + 1;
        at       = 0;
        send_poll(raw, start);
        forever begin
            nxt = at + $urandom_range(1, max_step);
            if (at < win && nxt > win)
                nxt = win;
            if (nxt >= span)
                break;
            at = nxt;
            send_poll(raw, start + at);
        end
        clock_ms = start + span;
    endtask

    // Contact bounce: n random levels, each 0 to 3 ms after the last
    task automatic chatter(int n);
        repeat (n) begin
            clock_ms = clock_ms + $urandom_range(0, 3);
            send_poll(1'($urandom_range(0, 1)), clock_ms);
        end
    endtask

    // Random levels with small steps, jumps anywhere and wrap crossings
    task automatic noise_burst(int n);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0:       clock_ms = $urandom();
                1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
                default: clock_ms = clock_ms + $urandom_range(0, 5);
            endcase
            send_poll(1'($urandom_range(0, 1)), clock_ms);
        end
    endtask

    // Press lengths clustered on the short and long limits and the debounce window
    function automatic int unsigned pick_press_span();
        int unsigned s, l, w;
        s = 32'(tracker.short_ms);
        l = 32'(tracker.long_ms);
        w = 32'(tracker.debounce_ms);
        case ($urandom_range(0, 9))
            0:       return s;
            1:       return s + 1;
            2:       return (l > 0) ? l - 1 : 0;
            3:       return l;
            4:       return $urandom_range(s, l);
            5:       return l + $urandom_range(0, 500);
            6:       return $urandom_range(0, w + 5);
            default: return $urandom_range(w, w + s);
        endcase
    endfunction

    // Release gaps around the double-press window
    function automatic int unsigned pick_release_span();
        int unsigned g, w;
        g = 32'(tracker.gap_ms);
        w = 32'(tracker.debounce_ms);
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, g + w);
            1:       return g + w;
            2:       return g + w + $urandom_range(1, 50);
            3:       return $urandom_range(0, w);
            4:       return $urandom_range(w, 2 * (g + w) + 10);
            default: return g + w + $urandom_range(0, 3000);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int stop_at;
        int r;
        tracker       = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_raw_pressed = 1'b0;
        i_now_ms      = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_DEBOUNCE_WINDOW;
        i_cfg_data    = '0;
        clock_ms      = '0;
        polls_sent    = 0;
        cycle_count   = 0;
        send_jitter   = 1'b1;
        stall_jitter  = 1'b1;
        hold_off_req  = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed polls at the reset settings (30 / 800 / 400 / 300 ms)
        send_poll(1'b0, 32'd0);
        // lone short press, single once the gap has passed
        send_poll(1'b1, 32'd1000);
        send_poll(1'b1, 32'd1030);
        send_poll(1'b0, 32'd1200);
        send_poll(1'b0, 32'd1230);
        send_poll(1'b0, 32'd1530);
        // double: second press still held at the gap deadline
        send_poll(1'b1, 32'd2000);
        send_poll(1'b1, 32'd2030);
        send_poll(1'b0, 32'd2100);
        send_poll(1'b0, 32'd2130);
        send_poll(1'b1, 32'd2200);
        send_poll(1'b1, 32'd2230);
        send_poll(1'b1, 32'd2460);
        send_poll(1'b0, 32'd2500);
        send_poll(1'b0, 32'd2530);
        // long hold
        send_poll(1'b1, 32'd3000);
        send_poll(1'b1, 32'd3030);
        send_poll(1'b0, 32'd3900);
        send_poll(1'b0, 32'd3930);
        // middle length, ignored
        send_poll(1'b1, 32'd5000);
        send_poll(1'b1, 32'd5030);
        send_poll(1'b0, 32'd5600);
        send_poll(1'b0, 32'd5630);
        // window sum wraps to zero, then a window that closes early at the wrap
        send_poll(1'b1, 32'hFFFF_FFE2);
        send_poll(1'b0, 32'hFFFF_FFFF);
        send_poll(1'b0, 32'hFFFF_FFFF);
        clock_ms = 32'd10000;

        // Random phases, each with its own settings
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: apply_settings(16'd5, 16'd200, 16'd100, 16'd150);
                1: apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
                2: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: apply_settings(16'd0, 16'd300, 16'd600, 16'd100);
                4: apply_settings(16'd50, 16'd1000, 16'd1000, 16'd0);
                default: apply_settings(CFG_W'($urandom_range(0, 200)),
                                        CFG_W'($urandom_range(0, 3000)),
                                        CFG_W'($urandom_range(0, 2000)),
                                        CFG_W'($urandom_range(0, 1000)));
            endcase
            // back-pressure burst: receiver holds off, sender keeps offering
            hold_off_req = 1'b1;
            send_jitter  = 1'b0;
            stop_at      = polls_sent + PHASE_POLLS;
            while (polls_sent < stop_at) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                if (r >= 90) begin
                    noise_burst($urandom_range(2, 8));
                end else begin
                    if ($urandom_range(0, 3) == 0)
                        chatter($urandom_range(1, 4));
                    level_run(1'b1, pick_press_span());
                    if ($urandom_range(0, 3) == 0)
                        chatter($urandom_range(1, 4));
                    level_run(1'b0, pick_release_span());
                end
                send_jitter  = ($urandom_range(0, 4) != 0);
                stall_jitter = ($urandom_range(0, 4) != 0);
            end
        end

        // Wait out the last gestures
        stall_jitter = 1'b1;
        drain_block();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.due_gestures.size() == 0)
            $display("PASS button_debounce_gesture_classifier");
        else
            $display("FAIL button_debounce_gesture_classifier");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/bdgc_pkg.sv
hdl/button_debounce_gesture_classifier.sv
tb/tb_button_debounce_gesture_classifier.sv
